### hw/rtl/whist_pkg.sv
// Shared types and constants for the weighted histogram accumulator.
`default_nettype none

package whist_pkg;

  // Field widths fixed by the item format
  localparam int VAL_W       = 32;
  localparam int VOL_W       = 48;
  localparam int BIN_W       = 6;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_OUT_BINS = 64;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MINIMUM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd2;

  // Reset values of the configuration registers
  localparam logic [VAL_W-1:0]   RST_MINIMUM   = 32'h0000_0000;
  localparam logic [VAL_W-1:0]   RST_INV_WIDTH = 32'h0001_0000;
  localparam logic [COUNT_W-1:0] RST_BIN_COUNT = 7'd50;

  // Operation handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_MERGE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             hit;
    logic [BIN_W-1:0] bin;
    logic [VOL_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### hw/rtl/whist_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module whist_ram #(
  parameter int WIDTH  = 48,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/whist_front.sv
// Front end: config registers, bin and contribution arithmetic, item classification.
`default_nettype none

module whist_front
  import whist_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_wr_t             cfg,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [VAL_W-1:0]    in_value,
  input  wire logic [VAL_W-1:0]    in_weight,
  input  wire logic [VAL_W-1:0]    in_factor,
  input  wire logic [BIN_W-1:0]    in_sel,
  input  wire logic [VOL_W-1:0]    in_mvol,
  output      logic                push,
  output      cmd_t                cmd,
  input  wire logic                q_full
);

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  // Configuration registers
  logic [VAL_W-1:0]   min_r;
  logic [VAL_W-1:0]   inv_r;
  logic [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= RST_MINIMUM;
      inv_r   <= RST_INV_WIDTH;
      count_r <= RST_BIN_COUNT;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_MINIMUM:   min_r   <= cfg.data;
        REG_INV_WIDTH: inv_r   <= cfg.data;
        REG_BIN_COUNT: count_r <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bins in use
  logic [COUNT_W-1:0] n_use;
  assign n_use = (count_r > DEPTH_C) ? DEPTH_C : count_r;

  // Pipeline control
  logic f1_valid_r, f2_valid_r;
  logic f1_adv, f2_adv;

  assign f2_adv   = f2_valid_r && !q_full;
  assign f1_adv   = f1_valid_r && (!f2_valid_r || f2_adv);
  assign in_ready = !f1_valid_r || f1_adv;
  assign push     = f2_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        f1_valid_r <= in_valid;
      end
      if (!f2_valid_r || f2_adv) begin
        f2_valid_r <= f1_adv;
      end
    end
  end

  // Stage 1: exact 33-bit difference to the lower edge
  logic [VAL_W:0]      diff_nxt;
  logic [KIND_W-1:0]   f1_kind_r;
  logic [VAL_W:0]      f1_diff_r;
  logic [VAL_W-1:0]    f1_weight_r;
  logic [VAL_W-1:0]    f1_factor_r;
  logic [BIN_W-1:0]    f1_sel_r;
  logic [VOL_W-1:0]    f1_mvol_r;

  assign diff_nxt = {in_value[VAL_W-1], in_value} - {min_r[VAL_W-1], min_r};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f1_kind_r   <= in_kind;
      f1_diff_r   <= diff_nxt;
      f1_weight_r <= in_weight;
      f1_factor_r <= in_factor;
      f1_sel_r    <= in_sel;
      f1_mvol_r   <= in_mvol;
    end
  end

  // Stage 2: bin index product and weighted contribution
  logic [2*VAL_W-1:0] bin_prod;
  logic [2*VAL_W-1:0] wt_prod;
  logic [KIND_W-1:0]  f2_kind_r;
  logic               f2_neg_r;
  logic [VAL_W-1:0]   f2_bin_r;
  logic [VOL_W-1:0]   f2_contrib_r;
  logic [BIN_W-1:0]   f2_sel_r;
  logic [VOL_W-1:0]   f2_mvol_r;

  assign bin_prod = {{VAL_W{1'b0}}, f1_diff_r[VAL_W-1:0]} * {{VAL_W{1'b0}}, inv_r};
  assign wt_prod  = {{VAL_W{1'b0}}, f1_weight_r} * {{VAL_W{1'b0}}, f1_factor_r};

  always_ff @(posedge clk) begin
    if (f1_adv) begin
      f2_kind_r    <= f1_kind_r;
      f2_neg_r     <= f1_diff_r[VAL_W];
      f2_bin_r     <= bin_prod[2*VAL_W-1:VAL_W];
      f2_contrib_r <= wt_prod[2*VAL_W-1:16];
      f2_sel_r     <= f1_sel_r;
      f2_mvol_r    <= f1_mvol_r;
    end
  end

  // Classification into a back-end command
  logic samp_hit, sel_hit;
  assign samp_hit = !f2_neg_r && (f2_bin_r < VAL_W'(n_use));
  assign sel_hit  = COUNT_W'(f2_sel_r) < n_use;

  always_comb begin
    cmd = '0;
    case (f2_kind_r)
      KIND_SAMPLE: begin
        cmd.op     = OP_SAMPLE;
        cmd.hit    = samp_hit;
        cmd.bin    = samp_hit ? f2_bin_r[BIN_W-1:0] : '0;
        cmd.amount = f2_contrib_r;
      end
      KIND_CLEAR: begin
        cmd.op = OP_CLEAR;
      end
      KIND_READ: begin
        cmd.op  = OP_READ;
        cmd.hit = sel_hit;
        cmd.bin = f2_sel_r;
      end
      KIND_MERGE: begin
        cmd.op     = OP_MERGE;
        cmd.hit    = sel_hit;
        cmd.bin    = f2_sel_r;
        cmd.amount = f2_mvol_r;
      end
      default: begin
        cmd.op = OP_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/whist_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module whist_queue
  import whist_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      cmd_t head_o,
  output      logic empty_o
);

  cmd_t       slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign full_o  = (count_r == 2'd2);
  assign empty_o = (count_r == 2'd0);
  assign head_o  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wptr_r] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_r <= !wptr_r;
      end
      if (pop_i) begin
        rptr_r <= !rptr_r;
      end
      case ({push_i, pop_i})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o) else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o) else $error("queue pushed while full");

endmodule

`default_nettype wire

### hw/rtl/whist_back.sv
// Back end: bin read-modify-write with saturation, valid flags, result register.
`default_nettype none

module whist_back
  import whist_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             head,
  input  wire logic             q_empty,
  output      logic             pop,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [BIN_W-1:0] out_bin,
  output      logic [VOL_W-1:0] out_vol,
  output      logic             out_hit
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  logic [DEPTH-1:0]  valid_r;
  logic              out_valid_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic [VOL_W-1:0]  out_vol_r;
  logic              out_hit_r;

  logic              go;
  logic              wr_en;
  logic [ADDR_W-1:0] addr;
  logic [VOL_W-1:0]  rd_data;
  logic [VOL_W-1:0]  cur;
  logic [VOL_W:0]    sum;
  logic [VOL_W-1:0]  sat;
  logic              is_add;

  assign pop  = (state_r == ST_IDLE) && !q_empty;
  assign go   = (state_r == ST_CALC) && (!out_valid_r || out_ready);
  assign addr = cmd_r.bin[ADDR_W-1:0];

  // Volume store
  whist_ram #(
    .WIDTH (VOL_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(addr),
    .wr_data(sat),
    .rd_en  (pop),
    .rd_addr(head.bin[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  // Saturating update of the selected bin
  assign cur    = (cmd_r.hit && valid_r[addr]) ? rd_data : '0;
  assign sum    = {1'b0, cur} + {1'b0, cmd_r.amount};
  assign sat    = sum[VOL_W] ? {VOL_W{1'b1}} : sum[VOL_W-1:0];
  assign is_add = cmd_r.hit && (cmd_r.op == OP_SAMPLE || cmd_r.op == OP_MERGE);
  assign wr_en  = go && is_add;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pop) state_nxt = ST_CALC;
      ST_CALC: if (go)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
  end

  // Control state: sequencer, valid flags, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go && cmd_r.op == OP_CLEAR) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (go) begin
      out_bin_r <= cmd_r.bin;
      out_hit_r <= cmd_r.hit;
      out_vol_r <= !cmd_r.hit ? '0 : (is_add ? sat : cur);
    end
  end

  assign out_valid = out_valid_r;
  assign out_bin   = out_bin_r;
  assign out_vol   = out_vol_r;
  assign out_hit   = out_hit_r;

  a_load_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CALC))
    else $error("result loaded outside calc step");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(addr)])
    else $error("bin written but not marked valid");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (go && cmd_r.op == OP_CLEAR) |=> (valid_r == '0))
    else $error("clear left a bin valid");

endmodule

`default_nettype wire

### hw/rtl/weighted_histogram_accumulator.sv
// Path from an accepted input word to out_tvalid high: difference stage, product
// stage, queue, RAM read, update; it stalls while the queue is busy or the
// result is held. The back end takes one command at a time: it pops a new one only
// after its read-then-write pass over the volume RAM for the last one is done.
// Reset (rst_n low, synchronous): config registers to their defaults, queue
// and pipeline empty, all bin valid flags cleared at once so every bin reads 0.
// Top level: weighted histogram accumulator with a stream interface.
`default_nettype none

module weighted_histogram_accumulator
  import whist_pkg::*;
#(
  parameter int MAX_BINS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // sample_value[31:0], jacobian_weight[63:32], coord_factor[95:64],
  // bin_select[101:96], merge_volume[149:102], zero pad[151:150]
  input  wire logic [151:0]          in_tdata,
  // kind[1:0]
  input  wire logic [KIND_W-1:0]     in_tuser,
  // Result stream
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // bin_index[5:0], bin_volume[53:6], zero pad[55:54]
  output      logic [55:0]           out_tdata,
  // in_range[0]
  output      logic                  out_tuser
);

  localparam int DEPTH  = (MAX_BINS < NUM_OUT_BINS) ? MAX_BINS : NUM_OUT_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_wr_t          cfg;
  cmd_t             push_cmd, head_cmd;
  logic             push, q_full, q_empty, pop;
  logic [BIN_W-1:0] out_bin;
  logic [VOL_W-1:0] out_vol;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_wdata};

  whist_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_value (in_tdata[31:0]),
    .in_weight(in_tdata[63:32]),
    .in_factor(in_tdata[95:64]),
    .in_sel   (in_tdata[101:96]),
    .in_mvol  (in_tdata[149:102]),
    .push     (push),
    .cmd      (push_cmd),
    .q_full   (q_full)
  );

  whist_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  whist_back #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_bin  (out_bin),
    .out_vol  (out_vol),
    .out_hit  (out_tuser)
  );

  assign out_tdata = {2'b00, out_vol, out_bin};

endmodule

`default_nettype wire
